[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent on one edge implies a consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/rrp_pkg.sv]
// Types and constants shared by the read-record response parser.
package rrp_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_RECORD     = 2'd1,
    REG_SUCCESS    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_SINGLE_RECORD    = 2'd0,
    MODE_MULTI_RECORD     = 2'd1,
    MODE_SINGLE_COUNTER   = 2'd2,
    MODE_MULTI_COUNTER    = 2'd3
  } struct_mode_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_kind_t;

  localparam logic [1:0]  ModeReset    = 2'd0;
  localparam logic [7:0]  RecordReset  = 8'd1;
  localparam logic [15:0] SuccessReset = 16'h9000;
  localparam logic [7:0]  CounterFirst = 8'd1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] status_word;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  entry_key;
    logic [23:0] entry_value;
    logic        end_of_entry;
    logic        empty_record;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  structure_mode;
    logic [7:0]  record_number;
    logic [15:0] success_status;
  } cfg_t;

endpackage

[hw/rtl/rrp_parse.sv]
// Parse state and per-byte decode of the read-record response data.
module rrp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  rrp_pkg::in_item_t item,
  input  rrp_pkg::cfg_t     cfg,
  output logic             has_result,
  output rrp_pkg::out_item_t result
);
  import rrp_pkg::*;

  typedef enum logic [1:0] {
    PH_RECNUM = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  logic        response_ok, response_ok_next;
  phase_t      parse_phase, parse_phase_next;
  logic [7:0]  current_record, current_record_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [15:0] counter_partial, counter_partial_next;
  logic [1:0]  counter_byte_pos, counter_byte_pos_next;
  logic [7:0]  counter_index, counter_index_next;
  logic [7:0]  rem;
  logic        done, trunc;

  always_comb begin
    response_ok_next      = response_ok;
    parse_phase_next      = parse_phase;
    current_record_next   = current_record;
    bytes_remaining_next  = bytes_remaining;
    counter_partial_next  = counter_partial;
    counter_byte_pos_next = counter_byte_pos;
    counter_index_next    = counter_index;
    has_result            = 1'b0;
    result                = '0;
    rem                   = bytes_remaining - 8'd1;
    done                  = (rem == 8'd0);
    trunc                 = item.last_byte && !done;

    if (fire) begin
      if (item.req_type == REQ_START) begin
        response_ok_next      = (item.status_word == cfg.success_status);
        parse_phase_next      = PH_RECNUM;
        current_record_next   = '0;
        bytes_remaining_next  = '0;
        counter_partial_next  = '0;
        counter_byte_pos_next = '0;
        counter_index_next    = CounterFirst;
      end else if (response_ok) begin
        case (struct_mode_t'(cfg.structure_mode))
          MODE_SINGLE_RECORD: begin
            has_result          = 1'b1;
            result.entry_key    = cfg.record_number;
            result.entry_value  = {16'd0, item.data_byte};
            result.end_of_entry = item.last_byte;
          end
          MODE_MULTI_RECORD: begin
            case (parse_phase)
              PH_LENGTH: begin
                if (item.data_byte == 8'd0) begin
                  has_result          = 1'b1;
                  result.entry_key    = current_record;
                  result.end_of_entry = 1'b1;
                  result.empty_record = 1'b1;
                  parse_phase_next    = PH_RECNUM;
                end else if (item.last_byte) begin
                  has_result          = 1'b1;
                  result.entry_key    = current_record;
                  result.end_of_entry = 1'b1;
                  result.truncated    = 1'b1;
                end else begin
                  bytes_remaining_next = item.data_byte;
                  parse_phase_next     = PH_DATA;
                end
              end
              PH_DATA: begin
                has_result           = 1'b1;
                result.entry_key     = current_record;
                result.entry_value   = {16'd0, item.data_byte};
                result.end_of_entry  = done || trunc;
                result.truncated     = trunc;
                bytes_remaining_next = rem;
                if (done) begin
                  parse_phase_next = PH_RECNUM;
                end
              end
              default: begin
                current_record_next = item.data_byte;
                parse_phase_next    = PH_LENGTH;
                if (item.last_byte) begin
                  has_result          = 1'b1;
                  result.entry_key    = item.data_byte;
                  result.end_of_entry = 1'b1;
                  result.truncated    = 1'b1;
                end
              end
            endcase
          end
          default: begin
            // counter modes: big-endian 3-byte values
            case (counter_byte_pos)
              2'd0: begin
                counter_partial_next  = {8'd0, item.data_byte};
                counter_byte_pos_next = 2'd1;
              end
              2'd1: begin
                counter_partial_next  = {counter_partial[7:0], item.data_byte};
                counter_byte_pos_next = 2'd2;
              end
              default: begin
                has_result            = 1'b1;
                result.entry_key      = counter_index;
                result.entry_value    = {counter_partial, item.data_byte};
                result.end_of_entry   = 1'b1;
                counter_index_next    = counter_index + 8'd1;
                counter_partial_next  = '0;
                counter_byte_pos_next = 2'd0;
              end
            endcase
          end
        endcase

        if (item.last_byte) begin
          response_ok_next      = 1'b0;
          parse_phase_next      = PH_RECNUM;
          current_record_next   = '0;
          bytes_remaining_next  = '0;
          counter_partial_next  = '0;
          counter_byte_pos_next = '0;
          counter_index_next    = CounterFirst;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_ok      <= 1'b0;
      parse_phase      <= PH_RECNUM;
      current_record   <= '0;
      bytes_remaining  <= '0;
      counter_partial  <= '0;
      counter_byte_pos <= '0;
      counter_index    <= CounterFirst;
    end else begin
      response_ok      <= response_ok_next;
      parse_phase      <= parse_phase_next;
      current_record   <= current_record_next;
      bytes_remaining  <= bytes_remaining_next;
      counter_partial  <= counter_partial_next;
      counter_byte_pos <= counter_byte_pos_next;
      counter_index    <= counter_index_next;
    end
  end

endmodule

[hw/rtl/record_response_parser.sv]
// Top level of the read-record response parser: config port, parser, result buffer.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+---------------------------
//   item      | item_valid / item_ready      | item   (rrp_pkg::in_item_t)
//   result    | result_valid / result_ready  | result (rrp_pkg::out_item_t)
//   config    | psel / penable / pwrite      | paddr, pwdata, prdata
//
// One item is taken per cycle while the skid register is empty; the parse state
// updates in the cycle of the transaction and its result is registered into the
// output register, or into the skid register while the output register is held.
// A two-entry result buffer (output register plus skid register) lets the block
// take one more result-producing item after the downstream side stalls; item_ready
// drops only while the skid register is full.
// Reset (rst, synchronous, active high) empties the buffer, clears the parse
// state and loads the register defaults; no clearing pass is needed.
module record_response_parser (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  rrp_pkg::in_item_t             item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output rrp_pkg::out_item_t            result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrp_pkg::AddrWidth-1:0] paddr,
  input  logic [rrp_pkg::DataWidth-1:0] pwdata,
  output logic [rrp_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import rrp_pkg::*;

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;

  logic       item_fire;
  logic       has_result;
  out_item_t  parsed;

  logic       skid_valid;
  out_item_t  skid;
  logic       pop;

  // Configuration registers: word-addressed, low address bits ignored.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.structure_mode <= ModeReset;
      cfg.record_number  <= RecordReset;
      cfg.success_status <= SuccessReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MODE:    cfg.structure_mode <= pwdata[1:0];
        REG_RECORD:  cfg.record_number  <= pwdata[7:0];
        REG_SUCCESS: cfg.success_status <= pwdata[15:0];
        default: begin
          // unmapped register: drop the write
        end
      endcase
    end
  end

  // Readback of the register selected by paddr.
  always_comb begin
    case (reg_sel)
      REG_MODE:    prdata = {30'd0, cfg.structure_mode};
      REG_RECORD:  prdata = {24'd0, cfg.record_number};
      REG_SUCCESS: prdata = {16'd0, cfg.success_status};
      default:     prdata = '0;
    endcase
  end

  // Parse each item in the cycle it is accepted.
  assign item_ready = !skid_valid;
  assign item_fire  = item_valid && item_ready;

  rrp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .fire       (item_fire),
    .item       (item),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (parsed)
  );

  // Result buffer: output register in front, skid register behind it.
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        // advance the skid entry; a new result refills the skid slot
        result_valid <= 1'b1;
        skid_valid   <= has_result;
      end else begin
        result_valid <= has_result;
      end
    end else if (!result_valid) begin
      result_valid <= has_result;
    end else if (has_result) begin
      // output held by downstream: park the new result
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        result <= skid;
        skid   <= parsed;
      end else begin
        result <= parsed;
      end
    end else if (!result_valid) begin
      result <= parsed;
    end else if (has_result) begin
      skid <= parsed;
    end
  end

endmodule

[hw/rtl/rrp_checker.sv]
// Port-level checker for the read-record response parser and its bind.
`include "assert_macros.svh"

module rrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input rrp_pkg::in_item_t             item,
  input logic                          result_valid,
  input logic                          result_ready,
  input rrp_pkg::out_item_t            result,
  input logic                          pready
);
  import rrp_pkg::*;

  // a stalled result stays put
  `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

  // with the output register empty there is room for an item
  `ASSERT_IMPL(a_ready_when_empty, !result_valid, item_ready, "item_ready low with empty output")

  // a start transaction never produces a result
  `ASSERT_NEXT(a_start_silent, item_valid && item_ready && item.req_type == REQ_START && !result_valid, !result_valid, "start transaction produced a result")

  // the configuration port never waits
  `ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind record_response_parser rrp_checker u_rrp_checker (.*);

[tb/record_response_parser_checker.sv]
// Checker for the read-record response parser: predicts results and compares them.
`timescale 1ns / 100ps

module record_response_parser_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  rrp_pkg::in_item_t             item,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  rrp_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrp_pkg::AddrWidth-1:0] paddr,
  input  logic [rrp_pkg::DataWidth-1:0] pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending_count
);
  import rrp_pkg::*;

  typedef enum logic [1:0] {
    EXPECT_RECORD = 2'd0,
    EXPECT_LENGTH = 2'd1,
    IN_DATA       = 2'd2
  } walk_phase_t;

  // Shadow copy of the configuration registers.
  struct_mode_t structure_mode;
  logic [7:0]   record_number;
  logic [15:0]  success_status;

  // Shadow copy of the parse state.
  logic         response_ok;
  walk_phase_t  walk_phase;
  logic [7:0]   current_record;
  logic [7:0]   bytes_left;
  logic [15:0]  counter_partial;
  logic [1:0]   counter_pos;
  logic [7:0]   counter_index;

  out_item_t    pending_entries[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic out_item_t make_entry(logic [7:0] key, logic [23:0] value, logic eoe,
                                           logic empty, logic trunc);
    out_item_t e;
    e.entry_key    = key;
    e.entry_value  = value;
    e.end_of_entry = eoe;
    e.empty_record = empty;
    e.truncated    = trunc;
    return e;
  endfunction

  function automatic void clear_parse();
    walk_phase      = EXPECT_RECORD;
    current_record  = 8'd0;
    bytes_left      = 8'd0;
    counter_partial = 16'd0;
    counter_pos     = 2'd0;
    counter_index   = CounterFirst;
  endfunction

  // Advance the parse state by one accepted transaction and queue any entry it yields.
  task automatic parse_item(input in_item_t it);
    logic [7:0] left_next;
    logic       done;
    logic       cut;
    if (it.req_type == REQ_START) begin
      response_ok = (it.status_word == success_status);
      clear_parse();
      return;
    end
    if (!response_ok) return;
    case (structure_mode)
      MODE_SINGLE_RECORD: begin
        pending_entries.push_back(make_entry(record_number, {16'd0, it.data_byte},
                                             it.last_byte, 1'b0, 1'b0));
      end
      MODE_MULTI_RECORD: begin
        case (walk_phase)
          EXPECT_LENGTH: begin
            if (it.data_byte == 8'd0) begin
              pending_entries.push_back(make_entry(current_record, 24'd0, 1'b1, 1'b1, 1'b0));
              walk_phase = EXPECT_RECORD;
            end else if (it.last_byte) begin
              pending_entries.push_back(make_entry(current_record, 24'd0, 1'b1, 1'b0, 1'b1));
            end else begin
              bytes_left = it.data_byte;
              walk_phase = IN_DATA;
            end
          end
          IN_DATA: begin
            left_next = bytes_left - 8'd1;
            done      = (left_next == 8'd0);
            cut       = it.last_byte && !done;
            pending_entries.push_back(make_entry(current_record, {16'd0, it.data_byte},
                                                 done | cut, 1'b0, cut));
            bytes_left = left_next;
            if (done) walk_phase = EXPECT_RECORD;
          end
          default: begin
            current_record = it.data_byte;
            walk_phase     = EXPECT_LENGTH;
            if (it.last_byte)
              pending_entries.push_back(make_entry(current_record, 24'd0, 1'b1, 1'b0, 1'b1));
          end
        endcase
      end
      default: begin
        case (counter_pos)
          2'd0: begin
            counter_partial = {8'd0, it.data_byte};
            counter_pos     = 2'd1;
          end
          2'd1: begin
            counter_partial = {counter_partial[7:0], it.data_byte};
            counter_pos     = 2'd2;
          end
          default: begin
            pending_entries.push_back(make_entry(counter_index, {counter_partial, it.data_byte},
                                                 1'b1, 1'b0, 1'b0));
            counter_index   = counter_index + 8'd1;
            counter_partial = 16'd0;
            counter_pos     = 2'd0;
          end
        endcase
      end
    endcase
    if (it.last_byte) begin
      response_ok = 1'b0;
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      structure_mode = struct_mode_t'(ModeReset);
      record_number  = RecordReset;
      success_status = SuccessReset;
      response_ok    = 1'b0;
      clear_parse();
      pending_entries.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[AddrWidth-1:2]))
          REG_MODE:    structure_mode = struct_mode_t'(pwdata[1:0]);
          REG_RECORD:  record_number  = pwdata[7:0];
          REG_SUCCESS: success_status = pwdata[15:0];
          default: ;
        endcase
      end
      // Results are registered before they leave, after their transaction, so check before predicting.
      if (result_valid && result_ready) begin
        if (pending_entries.size() == 0) begin
          $error("result with no expected entry: %p", result);
          fail_count++;
        end else begin
          want = pending_entries.pop_front();
          if (result.entry_key !== want.entry_key) begin
            $error("entry_key: expected %0h, actual %0h", want.entry_key, result.entry_key);
            fail_count++;
          end
          if (result.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0h, actual %0h", want.entry_value,
                   result.entry_value);
            fail_count++;
          end
          if (result.end_of_entry !== want.end_of_entry) begin
            $error("end_of_entry: expected %0b, actual %0b", want.end_of_entry,
                   result.end_of_entry);
            fail_count++;
          end
          if (result.empty_record !== want.empty_record) begin
            $error("empty_record: expected %0b, actual %0b", want.empty_record,
                   result.empty_record);
            fail_count++;
          end
          if (result.truncated !== want.truncated) begin
            $error("truncated: expected %0b, actual %0b", want.truncated, result.truncated);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) parse_item(item);
    end
    pending_count = pending_entries.size();
  end

endmodule

[tb/record_response_parser_test.sv]
// Top of the read-record response parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module record_response_parser_test;
  import rrp_pkg::*;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 25;
  localparam int LongHold      = 200;      // receiver hold-off that backs up the input
  localparam int SettleCycles  = 6;        // covers items that leave no result in flight
  localparam int CycleLimit    = 400000;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_ready;
  in_item_t             item;
  logic                 result_valid;
  logic                 result_ready;
  out_item_t            result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  int                   fail_count;
  int                   pending_count;
  int                   cycle_count = 0;

  // Stimulus knobs shared between the sender and the receiver process.
  int                   send_idle_pct;
  int                   stall_pct;
  logic                 hold_request;
  int                   items_sent;
  struct_mode_t         cur_mode;
  logic [15:0]          success_value;

  record_response_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  record_response_parser_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: drop ready at random per the current stall rate; on request, hold it
  // low for a long stretch so the result buffer fills and item_ready falls.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      result_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Write one register: setup cycle, then access cycle. Starts and ends on a falling edge.
  task automatic apb_write(input reg_index_t idx, input logic [DataWidth-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offer one transaction, optionally after idle cycles, and hold it until accepted.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Start of response; the unused byte fields carry random bits.
  task automatic send_start(input logic [15:0] sw);
    in_item_t it;
    it.req_type    = REQ_START;
    it.status_word = sw;
    it.data_byte   = 8'($urandom);
    it.last_byte   = 1'($urandom);
    send_item(it);
  endtask

  // Data byte; the status word is ignored here, so randomize it.
  task automatic send_data(input logic [7:0] b, input logic last);
    in_item_t it;
    it.req_type    = REQ_DATA;
    it.status_word = 16'($urandom);
    it.data_byte   = b;
    it.last_byte   = last;
    send_item(it);
  endtask

  // Lower valid and wait until every predicted entry has come out, then wait out
  // SettleCycles for bytes that leave no result but may still be in the pipeline.
  task automatic settle();
    item_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // One response shaped for the current mode: mostly well formed, sometimes cut
  // short, sometimes left open, sometimes followed by stray or random transactions.
  task automatic send_response();
    logic [7:0] body[$];
    logic [7:0] len;
    int         n;
    int         pick;
    send_start(($urandom_range(99) < 80) ? success_value : 16'($urandom));
    case (cur_mode)
      MODE_SINGLE_RECORD: begin
        repeat ($urandom_range(6)) body.push_back(8'($urandom));
      end
      MODE_MULTI_RECORD: begin
        repeat ($urandom_range(1, 4)) begin
          body.push_back(8'($urandom));
          // Mostly short records, now and then a long one.
          len = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 8)) : 8'($urandom_range(5));
          body.push_back(len);
          repeat (len) body.push_back(8'($urandom));
        end
      end
      default: begin
        // Whole counters, sometimes with a trailing partial one.
        n = $urandom_range(1, 4) * 3 + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
        repeat (n) body.push_back(8'($urandom));
      end
    endcase
    pick = $urandom_range(99);
    if (pick < 20 && body.size() > 0) body = body[0:$urandom_range(1, body.size()) - 1];
    for (int i = 0; i < body.size(); i++)
      send_data(body[i], (pick >= 30) && (i == body.size() - 1));
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 2)) send_data(8'($urandom), 1'($urandom));
    end else if (pick < 20) begin
      send_item(in_item_t'({1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom)}));
    end
  endtask

  struct_mode_t mode_plan[NumPhases] = '{MODE_SINGLE_RECORD, MODE_MULTI_RECORD,
                                         MODE_SINGLE_COUNTER, MODE_MULTI_COUNTER,
                                         MODE_MULTI_RECORD, MODE_SINGLE_RECORD,
                                         MODE_MULTI_COUNTER, MODE_MULTI_RECORD};

  initial begin
    int         target;
    logic [7:0] rec;
    // Drive every input to a known value from time zero.
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_request  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;
    cur_mode      = struct_mode_t'(ModeReset);
    success_value = SuccessReset;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part on the reset configuration: single record, key 1.
    // Extreme bytes, then a stray byte after the last one.
    send_start(SuccessReset);
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b1);
    send_data(8'h55, 1'b0);
    // Failed status: drop the data silently.
    send_start(16'h6A82);
    send_data(8'h12, 1'b1);
    // Empty single record: a start straight after a start.
    send_start(SuccessReset);
    send_start(SuccessReset);

    // Multiple records: empty record, full record, response ending after a record number.
    settle();
    apb_write(REG_MODE, 32'(MODE_MULTI_RECORD));
    send_start(SuccessReset);
    send_data(8'h03, 1'b0);
    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b0);
    send_data(8'h02, 1'b0);
    send_data(8'hAA, 1'b0);
    send_data(8'hBB, 1'b0);
    send_data(8'h07, 1'b1);
    // Response ending right after a nonzero length.
    send_start(SuccessReset);
    send_data(8'h08, 1'b0);
    send_data(8'h05, 1'b1);
    // Response ending inside record data.
    send_start(SuccessReset);
    send_data(8'h09, 1'b0);
    send_data(8'h03, 1'b0);
    send_data(8'h01, 1'b1);

    // Switch to counters mid-response: the parse state carries over.
    send_start(SuccessReset);
    send_data(8'h10, 1'b0);
    settle();
    apb_write(REG_MODE, 32'(MODE_SINGLE_COUNTER));
    send_data(8'h12, 1'b0);
    send_data(8'h34, 1'b0);
    send_data(8'h56, 1'b0);
    send_data(8'h78, 1'b1);

    // Random part: each phase picks a configuration and an idle pattern.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      cur_mode = mode_plan[p];
      rec = (p == 0) ? 8'h00 : (p == 5) ? 8'hFF : 8'($urandom);
      case (p)
        1:       success_value = 16'hFFFF;
        2:       success_value = 16'h0000;
        3, 7:    success_value = 16'($urandom);
        default: success_value = SuccessReset;
      endcase
      apb_write(REG_MODE, 32'(cur_mode));
      apb_write(REG_RECORD, 32'(rec));
      apb_write(REG_SUCCESS, 32'(success_value));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct     = 8;
        end
      endcase
      // Back up the block with a long receiver hold while items keep coming.
      if (p == 0) hold_request = 1'b1;
      // One long counter response so the counter index wraps past 255.
      if (p == 2) begin
        send_start(success_value);
        repeat (772) send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b1);
      end
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) send_response();
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_parse.sv
hw/rtl/record_response_parser.sv
hw/rtl/rrp_checker.sv
tb/record_response_parser_checker.sv
tb/record_response_parser_test.sv
